@@ rtl/display_command_framer_unit_assert.svh @@
// Assertion macros shared by the display command framer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef DISPLAY_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define DISPLAY_COMMAND_FRAMER_UNIT_ASSERT_SVH

// property holds on every cycle out of reset
`define DCF_ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dcf: invariant violated");

// consequent holds in the same cycle as the antecedent
`define DCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcf: implication violated");

// consequent holds in the cycle after the antecedent
`define DCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcf: next-cycle implication violated");

`endif

@@ rtl/dcf_pkg.sv @@
// Shared types and constants of the display command framer.
// No dependencies; imported by every framer module.
package dcf_pkg;

  localparam int CoordW = 12;
  localparam int ByteW  = 8;
  localparam int OpW    = 3;
  localparam int FlenW  = 16;

  localparam logic [OpW-1:0] OP_CLEAR      = 3'd0;
  localparam logic [OpW-1:0] OP_REFRESH    = 3'd1;
  localparam logic [OpW-1:0] OP_POINT      = 3'd2;
  localparam logic [OpW-1:0] OP_LINE       = 3'd3;
  localparam logic [OpW-1:0] OP_TEXT_BEGIN = 3'd4;
  localparam logic [OpW-1:0] OP_TEXT_CHAR  = 3'd5;

  localparam logic [ByteW-1:0] SYNC_BYTE   = 8'hA5;
  localparam logic [ByteW-1:0] TAIL_BYTE0  = 8'hCC;
  localparam logic [ByteW-1:0] TAIL_BYTE1  = 8'h33;
  localparam logic [ByteW-1:0] TAIL_BYTE2  = 8'hC3;
  localparam logic [ByteW-1:0] TAIL_BYTE3  = 8'h3C;
  localparam logic [ByteW-1:0] CMD_CLEAR   = 8'h2E;
  localparam logic [ByteW-1:0] CMD_REFRESH = 8'h0A;
  localparam logic [ByteW-1:0] CMD_POINT   = 8'h20;
  localparam logic [ByteW-1:0] CMD_LINE    = 8'h22;
  localparam logic [ByteW-1:0] CMD_TEXT    = 8'h30;

  localparam logic [FlenW-1:0] FLEN_SHORT = 16'd9;
  localparam logic [FlenW-1:0] FLEN_POINT = 16'd13;
  localparam logic [FlenW-1:0] FLEN_LINE  = 16'd17;

  localparam logic [1:0] REG_X_LIMIT  = 2'd0;
  localparam logic [1:0] REG_Y_LIMIT  = 2'd1;
  localparam logic [1:0] REG_TEXT_MAX = 2'd2;

  localparam logic [CoordW-1:0] X_LIMIT_RST  = 12'd800;
  localparam logic [CoordW-1:0] Y_LIMIT_RST  = 12'd600;
  localparam logic [CoordW-1:0] TEXT_MAX_RST = 12'd1020;

  typedef struct packed {
    logic [CoordW-1:0] x_limit;
    logic [CoordW-1:0] y_limit;
    logic [CoordW-1:0] text_max;
  } cfg_t;

  // one unit of back-end work: which frame segments to emit, and their data
  typedef struct packed {
    logic              has_hdr;
    logic              has_crd;
    logic              crd_line;
    logic              has_chr;
    logic              has_tail;
    logic [ByteW-1:0]  cmd;
    logic [FlenW-1:0]  flen;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x2;
    logic [CoordW-1:0] y2;
    logic [ByteW-1:0]  ch;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

endpackage

@@ rtl/dcf_front.sv @@
// Front end: accepts items, checks bounds, tracks the open text frame
// and pushes frame jobs. Depends on dcf_pkg.
`include "display_command_framer_unit_assert.svh"
module dcf_front import dcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OpW-1:0]    in_opcode,
  input  logic [CoordW-1:0] in_x_first,
  input  logic [CoordW-1:0] in_y_first,
  input  logic [CoordW-1:0] in_x_second,
  input  logic [CoordW-1:0] in_y_second,
  input  logic [CoordW-1:0] in_text_length,
  input  logic [ByteW-1:0]  in_char_byte,
  input  logic              q_full,
  output job_slot_t         q_push
);

  logic              text_open_r, text_open_nxt;
  logic [CoordW-1:0] chars_left_r, chars_left_nxt;
  logic              accept;
  logic              ok_first, ok_second;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign ok_first  = (in_x_first <= cfg.x_limit) && (in_y_first <= cfg.y_limit);
  assign ok_second = (in_x_second <= cfg.x_limit) && (in_y_second <= cfg.y_limit);

  always_comb begin
    text_open_nxt        = text_open_r;
    chars_left_nxt       = chars_left_r;
    q_push.valid         = 1'b0;
    q_push.job.has_hdr   = 1'b1;
    q_push.job.has_crd   = 1'b0;
    q_push.job.crd_line  = 1'b0;
    q_push.job.has_chr   = 1'b0;
    q_push.job.has_tail  = 1'b1;
    q_push.job.cmd       = CMD_CLEAR;
    q_push.job.flen      = FLEN_SHORT;
    q_push.job.x1        = in_x_first;
    q_push.job.y1        = in_y_first;
    q_push.job.x2        = in_x_second;
    q_push.job.y2        = in_y_second;
    q_push.job.ch        = in_char_byte;
    if (accept) begin
      priority if (in_opcode == OP_TEXT_CHAR) begin
        if (text_open_r) begin
          q_push.valid        = 1'b1;
          q_push.job.has_hdr  = 1'b0;
          q_push.job.has_chr  = 1'b1;
          q_push.job.has_tail = (chars_left_r == CoordW'(1));
          chars_left_nxt      = chars_left_r - CoordW'(1);
          if (chars_left_r == CoordW'(1)) begin
            text_open_nxt = 1'b0;
          end
        end
      end else if (!text_open_r) begin
        unique case (in_opcode)
          OP_CLEAR: begin
            q_push.valid = 1'b1;
          end
          OP_REFRESH: begin
            q_push.valid    = 1'b1;
            q_push.job.cmd  = CMD_REFRESH;
          end
          OP_POINT: begin
            q_push.valid       = ok_first;
            q_push.job.cmd     = CMD_POINT;
            q_push.job.flen    = FLEN_POINT;
            q_push.job.has_crd = 1'b1;
          end
          OP_LINE: begin
            q_push.valid        = ok_first && ok_second;
            q_push.job.cmd      = CMD_LINE;
            q_push.job.flen     = FLEN_LINE;
            q_push.job.has_crd  = 1'b1;
            q_push.job.crd_line = 1'b1;
          end
          OP_TEXT_BEGIN: begin
            q_push.valid        = ok_first && (in_text_length <= cfg.text_max);
            q_push.job.cmd      = CMD_TEXT;
            q_push.job.flen     = FLEN_POINT + FlenW'(in_text_length);
            q_push.job.has_crd  = 1'b1;
            q_push.job.has_tail = (in_text_length == '0);
            if (q_push.valid && in_text_length != '0) begin
              text_open_nxt  = 1'b1;
              chars_left_nxt = in_text_length;
            end
          end
          default: begin
            q_push.valid = 1'b0;
          end
        endcase
      end else begin
        // command while a text frame is open: dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_open_r  <= 1'b0;
      chars_left_r <= '0;
    end else begin
      text_open_r  <= text_open_nxt;
      chars_left_r <= chars_left_nxt;
    end
  end

  `DCF_ASSERT_SAME(a_open_has_chars, clk, rst_n, text_open_r, chars_left_r != '0)

endmodule

@@ rtl/dcf_queue.sv @@
// Job queue between front and back end, register based.
// Depends on dcf_pkg.
`include "display_command_framer_unit_assert.svh"
module dcf_queue import dcf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  job_slot_t push,
  output logic      full,
  output job_slot_t head,
  input  logic      pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  `DCF_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push.valid, !full)
  `DCF_ASSERT_HOLDS(a_count_bound, clk, rst_n, cnt_r <= CW'(DEPTH))

endmodule

@@ rtl/dcf_back.sv @@
// Back end: walks each job segment by segment, one frame byte per cycle unless
// stalled, keeps the running XOR and drives the output register. Depends on dcf_pkg.
`include "display_command_framer_unit_assert.svh"
module dcf_back import dcf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  job_slot_t        head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] out_byte,
  output logic             out_frame_last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_CRD  = 5'b00100,
    S_CHR  = 5'b01000,
    S_TAIL = 5'b10000
  } seg_state_t;

  seg_state_t       st_r, st_nxt, seg_after;
  logic [2:0]       cnt_r, cnt_nxt;
  job_t             job_r, job_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ByteW-1:0] out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [ByteW-1:0] byte_sel;
  logic             last_sel, seg_done, adv;

  function automatic seg_state_t next_seg(job_t j, seg_state_t from);
    seg_state_t r;
    r = S_IDLE;
    unique case (from)
      S_IDLE:  r = j.has_hdr ? S_HDR : j.has_crd ? S_CRD : j.has_chr ? S_CHR :
                   j.has_tail ? S_TAIL : S_IDLE;
      S_HDR:   r = j.has_crd ? S_CRD : j.has_chr ? S_CHR : j.has_tail ? S_TAIL : S_IDLE;
      S_CRD:   r = j.has_chr ? S_CHR : j.has_tail ? S_TAIL : S_IDLE;
      S_CHR:   r = j.has_tail ? S_TAIL : S_IDLE;
      S_TAIL:  r = S_IDLE;
      default: r = S_IDLE;
    endcase
    return r;
  endfunction

  assign adv            = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_last = out_last_r;
  assign seg_after      = next_seg(job_r, st_r);

  always_comb begin
    byte_sel = '0;
    last_sel = 1'b0;
    seg_done = 1'b0;
    unique case (st_r)
      S_HDR: begin
        seg_done = (cnt_r == 3'd3);
        unique case (cnt_r[1:0])
          2'd0: byte_sel = SYNC_BYTE;
          2'd1: byte_sel = job_r.flen[15:8];
          2'd2: byte_sel = job_r.flen[7:0];
          2'd3: byte_sel = job_r.cmd;
        endcase
      end
      S_CRD: begin
        seg_done = job_r.crd_line ? (cnt_r == 3'd7) : (cnt_r == 3'd3);
        unique case (cnt_r)
          3'd0: byte_sel = {4'b0, job_r.x1[11:8]};
          3'd1: byte_sel = job_r.x1[7:0];
          3'd2: byte_sel = {4'b0, job_r.y1[11:8]};
          3'd3: byte_sel = job_r.y1[7:0];
          3'd4: byte_sel = {4'b0, job_r.x2[11:8]};
          3'd5: byte_sel = job_r.x2[7:0];
          3'd6: byte_sel = {4'b0, job_r.y2[11:8]};
          3'd7: byte_sel = job_r.y2[7:0];
        endcase
      end
      S_CHR: begin
        seg_done = 1'b1;
        byte_sel = job_r.ch;
      end
      S_TAIL: begin
        seg_done = (cnt_r == 3'd4);
        unique case (cnt_r)
          3'd0:    byte_sel = TAIL_BYTE0;
          3'd1:    byte_sel = TAIL_BYTE1;
          3'd2:    byte_sel = TAIL_BYTE2;
          3'd3:    byte_sel = TAIL_BYTE3;
          default: begin
            byte_sel = xor_r;
            last_sel = 1'b1;
          end
        endcase
      end
      default: begin
        byte_sel = '0;
      end
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    job_nxt       = job_r;
    xor_nxt       = xor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (st_r == S_IDLE) begin
      if (head.valid) begin
        pop     = 1'b1;
        job_nxt = head.job;
        st_nxt  = next_seg(head.job, S_IDLE);
        cnt_nxt = '0;
      end
    end else if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_sel;
      out_last_nxt  = last_sel;
      priority if (last_sel) begin
        xor_nxt = '0;
      end else if (st_r == S_HDR && cnt_r == 3'd0) begin
        xor_nxt = byte_sel;
      end else begin
        xor_nxt = xor_r ^ byte_sel;
      end
      if (seg_done) begin
        cnt_nxt = '0;
        if (seg_after != S_IDLE) begin
          st_nxt = seg_after;
        end else if (head.valid) begin
          pop     = 1'b1;
          job_nxt = head.job;
          st_nxt  = next_seg(head.job, S_IDLE);
        end else begin
          st_nxt = S_IDLE;
        end
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `DCF_ASSERT_SAME(a_tail_only_when_flagged, clk, rst_n, st_r == S_TAIL, job_r.has_tail)
  `DCF_ASSERT_NEXT(a_xor_cleared_after_sum, clk, rst_n,
                   (st_r == S_TAIL) && adv && (cnt_r == 3'd4), xor_r == '0)

endmodule

@@ rtl/display_command_framer_unit.sv @@
// Display command framer: builds A5-headed serial command frames with an
// XOR checksum and emits them one byte per transfer. A front end accepts
// one item per cycle while the job queue is not full, checks it against
// the limit registers and queues a frame job; the back end turns each job
// into bytes at one byte per cycle whenever the output is not stalled, and
// passes through its idle state to fetch a job when it was idle. A clear or
// refresh frame is 9 bytes long, a point or empty text frame 13, a line
// frame 17; a text open emits 8 bytes, a text character 1 and the final
// character 6. Items are accepted every cycle until the job queue
// (QUEUE_DEPTH entries) fills, after which the front end stalls while it
// is full; rejected and ignored items are accepted but emit nothing.
// Depends on dcf_pkg, dcf_front, dcf_queue and dcf_back.
module display_command_framer_unit import dcf_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OpW-1:0]    in_opcode,
  input  logic [CoordW-1:0] in_x_first,
  input  logic [CoordW-1:0] in_y_first,
  input  logic [CoordW-1:0] in_x_second,
  input  logic [CoordW-1:0] in_y_second,
  input  logic [CoordW-1:0] in_text_length,
  input  logic [ByteW-1:0]  in_char_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  out_byte,
  output logic              out_frame_last
);

  cfg_t      cfg_r;
  job_slot_t q_push, q_head;
  logic      q_full, q_pop;
  logic      reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_limit  <= X_LIMIT_RST;
      cfg_r.y_limit  <= Y_LIMIT_RST;
      cfg_r.text_max <= TEXT_MAX_RST;
    end else if (reg_wr) begin
      if (paddr[3:2] == REG_X_LIMIT)  cfg_r.x_limit  <= pwdata[CoordW-1:0];
      if (paddr[3:2] == REG_Y_LIMIT)  cfg_r.y_limit  <= pwdata[CoordW-1:0];
      if (paddr[3:2] == REG_TEXT_MAX) cfg_r.text_max <= pwdata[CoordW-1:0];
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_LIMIT:  prdata = {20'b0, cfg_r.x_limit};
      REG_Y_LIMIT:  prdata = {20'b0, cfg_r.y_limit};
      REG_TEXT_MAX: prdata = {20'b0, cfg_r.text_max};
      default:      prdata = '0;
    endcase
  end

  dcf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_x_first     (in_x_first),
    .in_y_first     (in_y_first),
    .in_x_second    (in_x_second),
    .in_y_second    (in_y_second),
    .in_text_length (in_text_length),
    .in_char_byte   (in_char_byte),
    .q_full         (q_full),
    .q_push         (q_push)
  );

  dcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  dcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_frame_last (out_frame_last)
  );

endmodule
